// ===== sv/rpn_pkg.sv =====
package rpn_pkg;

  // Stack geometry and fixed-point format.
  localparam int STACK_DEPTH   = 64;
  localparam int FRACTION_BITS = 16;
  localparam int VALUE_W       = 32;
  localparam int SP_W          = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Divider geometry: the dividend is |a| scaled by 2^FRACTION_BITS, padded to
  // an even width because the divider retires two quotient bits per cycle.
  localparam int DIV_W     = VALUE_W + FRACTION_BITS;
  localparam int DIV_STEPS = (DIV_W + 1) / 2;
  localparam int DIV_PAD   = 2 * DIV_STEPS;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);
  localparam int REM_W     = VALUE_W + 1;

  // Rounding bias that turns an arithmetic shift into truncation toward zero.
  localparam logic [63:0] MUL_BIAS = (64'd1 << FRACTION_BITS) - 64'd1;

  // Command codes carried by the input item.
  typedef enum logic [2:0] {
    CMD_PUSH    = 3'd0,
    CMD_ADD     = 3'd1,
    CMD_SUB     = 3'd2,
    CMD_MUL     = 3'd3,
    CMD_DIV     = 3'd4,
    CMD_PRINT   = 3'd5,
    CMD_UNKNOWN = 3'd6
  } cmd_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic pop_rd;
    logic cap_b;
    logic cap_a;
    logic mul;
    logic div_start;
    logic div_step;
    logic calc;
    logic push;
    logic set_zd;
    logic out_load;
    cmd_t op;
  } rpn_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pop_zero;
    logic div_done;
  } rpn_stat_t;

  // Saturate a 64-bit signed value to the signed 32-bit range.
  function automatic logic signed [VALUE_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] vmax;
    logic signed [63:0] vmin;
    vmax = 64'sh0000_0000_7FFF_FFFF;
    vmin = -64'sh0000_0000_8000_0000;
    if (v > vmax) begin
      sat32 = VALUE_W'(vmax);
    end else if (v < vmin) begin
      sat32 = VALUE_W'(vmin);
    end else begin
      sat32 = v[VALUE_W-1:0];
    end
  endfunction

endpackage

// ===== sv/rpn_ctrl.sv =====
module rpn_ctrl
  import rpn_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic [2:0] in_cmd,
  output logic      out_valid,
  input  logic      out_stall,
  input  rpn_stat_t stat,
  output rpn_ctl_t  ctl
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POP_B,
    ST_GET_B,
    ST_POP_A,
    ST_GET_A,
    ST_MUL,
    ST_DIV_INIT,
    ST_DIV,
    ST_EXEC,
    ST_PUSH,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  cmd_t   op_r, op_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign accept    = in_valid && (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state, latched command and the result-valid flag.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_PUSH, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_PRINT: op_nxt = cmd_t'(in_cmd);
            default: op_nxt = CMD_UNKNOWN;
          endcase
          case (op_nxt)
            CMD_PUSH:    state_nxt = ST_PUSH;
            CMD_UNKNOWN: state_nxt = ST_DONE;
            default:     state_nxt = ST_POP_B;
          endcase
        end
      end
      ST_POP_B: state_nxt = ST_GET_B;
      ST_GET_B: begin
        if (op_r == CMD_PRINT) begin
          state_nxt = ST_DONE;
        end else if (op_r == CMD_DIV && stat.pop_zero) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_POP_A;
        end
      end
      ST_POP_A: state_nxt = ST_GET_A;
      ST_GET_A: begin
        case (op_r)
          CMD_MUL: state_nxt = ST_MUL;
          CMD_DIV: state_nxt = ST_DIV_INIT;
          default: state_nxt = ST_EXEC;
        endcase
      end
      ST_MUL:      state_nxt = ST_EXEC;
      ST_DIV_INIT: state_nxt = ST_DIV;
      ST_DIV: begin
        if (stat.div_done) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: state_nxt = ST_PUSH;
      ST_PUSH: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath commands decoded from the current state.
  always_comb begin
    ctl           = '0;
    ctl.op        = op_r;
    ctl.latch_in  = accept;
    ctl.pop_rd    = (state_r == ST_POP_B) || (state_r == ST_POP_A);
    ctl.cap_b     = (state_r == ST_GET_B);
    ctl.cap_a     = (state_r == ST_GET_A);
    ctl.mul       = (state_r == ST_MUL);
    ctl.div_start = (state_r == ST_DIV_INIT);
    ctl.div_step  = (state_r == ST_DIV) && !stat.div_done;
    ctl.calc      = (state_r == ST_EXEC);
    ctl.push      = (state_r == ST_PUSH);
    ctl.set_zd    = (state_r == ST_GET_B) && (op_r == CMD_DIV) && stat.pop_zero;
    ctl.out_load  = (state_r == ST_DONE) && out_free;
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= CMD_UNKNOWN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/rpn_dpath.sv =====
module rpn_dpath
  import rpn_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic signed [VALUE_W-1:0] in_number,
  input  rpn_ctl_t                  ctl,
  output rpn_stat_t                 stat,
  output logic                      out_print_valid,
  output logic signed [VALUE_W-1:0] out_print_value,
  output logic                      out_stack_underflow,
  output logic                      out_stack_overflow,
  output logic                      out_zero_divisor,
  output logic                      out_unknown_command
);

  // Value stack storage; entries above the pointer never reach an operand.
  logic [VALUE_W-1:0] stack_mem [STACK_DEPTH];

  logic [SP_W-1:0]           sp_r;
  logic [SP_W-1:0]           sp_m1;
  logic [ADDR_W-1:0]         rd_addr;
  logic [ADDR_W-1:0]         wr_addr;
  logic [VALUE_W-1:0]        rdata_r;
  logic                      pop_empty_r;
  logic signed [VALUE_W-1:0] pop_val;
  logic                      stack_full;
  logic signed [VALUE_W-1:0] push_val;

  logic signed [VALUE_W-1:0] number_r;
  logic signed [VALUE_W-1:0] a_r;
  logic signed [VALUE_W-1:0] b_r;
  logic signed [VALUE_W-1:0] res_r;
  logic signed [63:0]        prod_r;
  logic                      under_r;
  logic                      over_r;
  logic                      zd_r;

  // Divider state: dq holds remaining dividend bits and collects quotient bits.
  logic [DIV_PAD-1:0] dq_r;
  logic [REM_W-1:0]   rem_r;
  logic [REM_W-1:0]   dvs_r;
  logic [DCNT_W-1:0]  dcnt_r;
  logic               neg_r;
  logic [DIV_PAD-1:0] dq_nxt;
  logic [REM_W-1:0]   rem_nxt;
  logic [VALUE_W-1:0] a_mag;
  logic [VALUE_W-1:0] b_mag;

  logic signed [VALUE_W-1:0] calc_val;
  logic signed [63:0]        mul_biased;
  logic signed [63:0]        quot_s;

  assign sp_m1      = sp_r - SP_W'(1);
  assign rd_addr    = sp_m1[ADDR_W-1:0];
  assign wr_addr    = sp_r[ADDR_W-1:0];
  assign stack_full = (sp_r >= SP_W'(STACK_DEPTH));
  assign pop_val    = pop_empty_r ? '0 : $signed(rdata_r);
  assign push_val   = (ctl.op == CMD_PUSH) ? number_r : res_r;

  assign stat.pop_zero = (pop_val == '0);
  assign stat.div_done = (dcnt_r == '0);

  // Stack memory write and registered read.
  always_ff @(posedge clk) begin
    if (ctl.push && !stack_full) begin
      stack_mem[wr_addr] <= push_val;
    end
    if (ctl.pop_rd) begin
      rdata_r <= stack_mem[rd_addr];
    end
  end

  // Stack pointer and per-item flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      pop_empty_r <= 1'b0;
      under_r     <= 1'b0;
      over_r      <= 1'b0;
      zd_r        <= 1'b0;
    end else begin
      if (ctl.latch_in) begin
        under_r <= 1'b0;
        over_r  <= 1'b0;
        zd_r    <= 1'b0;
      end
      if (ctl.pop_rd) begin
        if (sp_r != '0) begin
          sp_r        <= sp_m1;
          pop_empty_r <= 1'b0;
        end else begin
          pop_empty_r <= 1'b1;
          under_r     <= 1'b1;
        end
      end
      if (ctl.push) begin
        if (!stack_full) begin
          sp_r <= sp_r + SP_W'(1);
        end else begin
          over_r <= 1'b1;
        end
      end
      if (ctl.set_zd) begin
        zd_r <= 1'b1;
      end
    end
  end

  // Operand magnitudes for the divider.
  assign a_mag = a_r[VALUE_W-1] ? VALUE_W'(-a_r) : VALUE_W'(a_r);
  assign b_mag = b_r[VALUE_W-1] ? VALUE_W'(-b_r) : VALUE_W'(b_r);

  // Two restoring division steps per cycle.
  always_comb begin
    logic [REM_W-1:0] r;
    logic [DIV_PAD-1:0] d;
    r = rem_r;
    d = dq_r;
    for (int i = 0; i < 2; i++) begin
      r = {r[REM_W-2:0], d[DIV_PAD-1]};
      if (r >= dvs_r) begin
        r = r - dvs_r;
        d = {d[DIV_PAD-2:0], 1'b1};
      end else begin
        d = {d[DIV_PAD-2:0], 1'b0};
      end
    end
    rem_nxt = r;
    dq_nxt  = d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (ctl.div_start) begin
      dcnt_r <= DCNT_W'(DIV_STEPS);
    end else if (ctl.div_step) begin
      dcnt_r <= dcnt_r - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      rem_r <= '0;
      dq_r  <= DIV_PAD'({a_mag, {FRACTION_BITS{1'b0}}});
      dvs_r <= REM_W'(b_mag);
      neg_r <= a_r[VALUE_W-1] ^ b_r[VALUE_W-1];
    end else if (ctl.div_step) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
    end
  end

  // Result of the arithmetic command, truncated toward zero and saturated.
  assign mul_biased = prod_r + (prod_r[63] ? $signed(MUL_BIAS) : 64'sd0);
  assign quot_s     = neg_r ? -$signed(64'(dq_r)) : $signed(64'(dq_r));

  always_comb begin
    case (ctl.op)
      CMD_ADD: calc_val = sat32(64'(a_r) + 64'(b_r));
      CMD_SUB: calc_val = sat32(64'(a_r) - 64'(b_r));
      CMD_MUL: calc_val = sat32(mul_biased >>> FRACTION_BITS);
      CMD_DIV: calc_val = sat32(quot_s);
      default: calc_val = '0;
    endcase
  end

  // Operand, product and result registers.
  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      number_r <= in_number;
    end
    if (ctl.cap_b) begin
      b_r <= pop_val;
    end
    if (ctl.cap_a) begin
      a_r <= pop_val;
    end
    if (ctl.mul) begin
      prod_r <= 64'(a_r) * 64'(b_r);
    end
    if (ctl.calc) begin
      res_r <= calc_val;
    end
  end

  // Result register shown on the output channel.
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_print_valid     <= (ctl.op == CMD_PRINT);
      out_print_value     <= (ctl.op == CMD_PRINT) ? b_r : '0;
      out_stack_underflow <= under_r;
      out_stack_overflow  <= over_r;
      out_zero_divisor    <= zd_r;
      out_unknown_command <= (ctl.op == CMD_UNKNOWN);
    end
  end

endmodule

// ===== sv/rpn_stack_calculator_core.sv =====
// An accepted push writes its number; a print pops one value; add, subtract,
// multiply and divide pop two, but a divide stops once a zero divisor pops.
// The divide time is set by the iterative divider, which retires two quotient
// bits per cycle over a 48-bit scaled dividend. One item is in work at a time;
// the next item can be accepted in the cycle the result is first shown as valid.
// Reset (rst_n low, synchronous) empties the stack; stack contents are not cleared.
module rpn_stack_calculator_core
  import rpn_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                in_cmd,
  input  logic signed [VALUE_W-1:0] in_number,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_print_valid,
  output logic signed [VALUE_W-1:0] out_print_value,
  output logic                      out_stack_underflow,
  output logic                      out_stack_overflow,
  output logic                      out_zero_divisor,
  output logic                      out_unknown_command
);

  rpn_ctl_t  ctl;
  rpn_stat_t stat;

  // Sequencing of pops, arithmetic, push and result transfer.
  rpn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  // Stack memory, operands, multiplier, divider and result register.
  rpn_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_number           (in_number),
    .ctl                 (ctl),
    .stat                (stat),
    .out_print_valid     (out_print_valid),
    .out_print_value     (out_print_value),
    .out_stack_underflow (out_stack_underflow),
    .out_stack_overflow  (out_stack_overflow),
    .out_zero_divisor    (out_zero_divisor),
    .out_unknown_command (out_unknown_command)
  );

endmodule

// ===== sv/rpn_checker.sv =====
module rpn_checker
  import rpn_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      out_print_valid,
  input logic signed [VALUE_W-1:0] out_print_value,
  input logic                      out_stack_underflow,
  input logic                      out_stack_overflow,
  input logic                      out_zero_divisor,
  input logic                      out_unknown_command
);

  // A stalled result holds its valid, its value, its print flag and its underflow flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_print_value)
      && $stable(out_print_valid) && $stable(out_stack_underflow))
    else $error("stalled result changed");

  // The block works on one item at a time, so it is busy after each transfer.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again in the cycle after a transfer");

  // Only a print shows a value.
  a_print_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_print_valid |-> out_print_value == '0)
    else $error("value shown on a result that is not a print");

  // Print and unknown command never push or divide.
  a_print_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_print_valid || out_unknown_command)
      |-> !out_stack_overflow && !out_zero_divisor)
    else $error("push or divide flag on a print or unknown command");

  // An unknown command leaves the stack untouched.
  a_unknown_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_unknown_command |-> !out_stack_underflow && !out_print_valid)
    else $error("unknown command touched the stack");

endmodule

bind rpn_stack_calculator_core rpn_checker u_rpn_checker (.*);
